[design/hufd_pkg.sv]
// Shared types and constants for the serialized-tree Huffman decoder.
// No dependencies; hufd_outq, hufd_ctrl and the top level import this package.
package hufd_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int STACK_DEPTH   = 256;

    localparam int NODE_MAX   = 2 * ALPHABET_SIZE - 1;
    localparam int NODE_AW    = $clog2(NODE_MAX);
    localparam int NODES_W    = $clog2(NODE_MAX + 1);
    localparam int STACK_AW   = $clog2(STACK_DEPTH);
    localparam int STACK_TW   = STACK_AW + 1;

    // Node entry: [18] leaf flag, [17:9] left index, [8:0] right index or symbol.
    localparam int NODE_IDX_W = 9;
    localparam int ENTRY_W    = 2 * NODE_IDX_W + 1;
    localparam int LEAF_BIT   = ENTRY_W - 1;
    localparam int SYM_W      = 8;

    typedef logic [ENTRY_W-1:0]    entry_t;
    typedef logic [NODE_IDX_W-1:0] node_idx_t;

    typedef enum logic [2:0] {
        PH_TREE,
        PH_LEAF,
        PH_SKIP,
        PH_DECODE,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_WALK,
        ENG_POP
    } eng_state_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             status;
        logic             last;
    } result_t;

    typedef struct packed {
        logic walking;
        logic popping;
    } ctrl_stat_t;

endpackage

[design/hufd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/hufd_outq.sv]
// Two-entry result buffer between the decode engine and the output stream.
// Depends on hufd_pkg.
module hufd_outq
    import hufd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  result_t          push,
    output logic             full,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [SYM_W-1:0] m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    result_t    q0_reg, q0_next;
    result_t    q1_reg, q1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop = (count_reg != 2'd0) && m_tready;

    always_comb
    begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        count_next = count_reg;
        if (pop)
        begin
            q0_next    = q1_reg;
            count_next = count_reg - 2'd1;
        end
        if (push.valid)
        begin
            // land in the first free slot after a possible pop
            if (count_next == 2'd0)
            begin
                q0_next = push;
            end
            else
            begin
                q1_next = push;
            end
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign full     = (count_reg == 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = q0_reg.symbol;
    assign m_tlast  = q0_reg.last;
    assign m_tuser  = q0_reg.status;

endmodule

[design/hufd_ctrl.sv]
// Tree load and decode sequencer around the node table and pending-stack RAMs.
// Depends on hufd_pkg; drives the two hufd_ram instances in the top level.
module hufd_ctrl
    import hufd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                code_bit,
    input  logic                byte_end,
    input  logic                frame_start,
    input  logic                q_full,
    output result_t             res,
    output ctrl_stat_t          stat,
    output logic                node_we,
    output logic [NODE_AW-1:0]  node_waddr,
    output entry_t              node_wdata,
    output logic                node_re,
    output logic [NODE_AW-1:0]  node_raddr,
    input  entry_t              node_rdata,
    output logic                stk_we,
    output logic [STACK_AW-1:0] stk_waddr,
    output node_idx_t           stk_wdata,
    output logic                stk_re,
    output logic [STACK_AW-1:0] stk_raddr,
    input  node_idx_t           stk_rdata
);

    phase_t               phase_reg, phase_next;
    eng_state_t           eng_reg, eng_next;
    logic [STACK_TW-1:0]  stack_top_reg, stack_top_next;
    logic [NODES_W-1:0]   nodes_used_reg, nodes_used_next;
    logic [SYM_W-1:0]     leaf_shift_reg, leaf_shift_next;
    logic [2:0]           leaf_bits_reg, leaf_bits_next;
    entry_t               cur_entry_reg, cur_entry_next;
    entry_t               root_entry_reg, root_entry_next;
    logic [31:0]          symbols_left_reg, symbols_left_next;
    logic [31:0]          symbol_count_reg;

    // state as seen by the accepted bit, after a frame start clear
    phase_t               ph_eff;
    logic [STACK_TW-1:0]  top_eff;
    logic [NODES_W-1:0]   used_eff;
    logic [SYM_W-1:0]     shift_eff;
    logic [2:0]           bits_eff;
    logic [SYM_W-1:0]     new_shift;
    logic [NODES_W-1:0]   leaf_pos;
    node_idx_t            walk_idx;
    logic                 accept;
    logic                 emit;
    logic [SYM_W-1:0]     emit_sym;

    assign accept   = in_valid && in_ready;
    assign in_ready = (eng_reg == ENG_IDLE) && !q_full;

    always_comb
    begin
        ph_eff    = frame_start ? PH_TREE : phase_reg;
        top_eff   = frame_start ? '0 : stack_top_reg;
        used_eff  = frame_start ? '0 : nodes_used_reg;
        shift_eff = frame_start ? '0 : leaf_shift_reg;
        bits_eff  = frame_start ? '0 : leaf_bits_reg;
        new_shift = {shift_eff[SYM_W-2:0], code_bit};
        leaf_pos  = used_eff - NODES_W'(1);
        walk_idx  = code_bit ? cur_entry_reg[NODE_IDX_W-1:0]
                             : cur_entry_reg[2*NODE_IDX_W-1:NODE_IDX_W];

        phase_next        = phase_reg;
        eng_next          = eng_reg;
        stack_top_next    = stack_top_reg;
        nodes_used_next   = nodes_used_reg;
        leaf_shift_next   = leaf_shift_reg;
        leaf_bits_next    = leaf_bits_reg;
        cur_entry_next    = cur_entry_reg;
        root_entry_next   = root_entry_reg;
        symbols_left_next = symbols_left_reg;

        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '0;
        node_re    = 1'b0;
        node_raddr = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_re     = 1'b0;
        stk_raddr  = '0;

        res      = '0;
        emit     = 1'b0;
        emit_sym = '0;

        unique case (eng_reg)
            ENG_IDLE:
            begin
                if (accept)
                begin
                    phase_next      = ph_eff;
                    stack_top_next  = top_eff;
                    nodes_used_next = used_eff;
                    leaf_shift_next = shift_eff;
                    leaf_bits_next  = bits_eff;
                    unique case (ph_eff)
                        PH_TREE:
                        begin
                            if (used_eff == NODES_W'(NODE_MAX))
                            begin
                                phase_next = PH_ERROR;
                                res.valid  = 1'b1;
                                res.status = 1'b1;
                            end
                            else if (code_bit)
                            begin
                                nodes_used_next = used_eff + NODES_W'(1);
                                leaf_shift_next = '0;
                                leaf_bits_next  = '0;
                                phase_next      = PH_LEAF;
                            end
                            else if (top_eff == STACK_TW'(STACK_DEPTH))
                            begin
                                phase_next = PH_ERROR;
                                res.valid  = 1'b1;
                                res.status = 1'b1;
                            end
                            else
                            begin
                                // internal node: left child is the next node
                                nodes_used_next = used_eff + NODES_W'(1);
                                node_we    = 1'b1;
                                node_waddr = NODE_AW'(used_eff);
                                node_wdata = {1'b0, NODE_IDX_W'(used_eff + NODES_W'(1)),
                                              NODE_IDX_W'(0)};
                                stk_we     = 1'b1;
                                stk_waddr  = top_eff[STACK_AW-1:0];
                                stk_wdata  = NODE_IDX_W'(used_eff);
                                stack_top_next = top_eff + STACK_TW'(1);
                                if (used_eff == '0)
                                begin
                                    root_entry_next = node_wdata;
                                end
                            end
                        end
                        PH_LEAF:
                        begin
                            leaf_shift_next = new_shift;
                            leaf_bits_next  = bits_eff + 3'd1;
                            if (bits_eff == 3'd7)
                            begin
                                leaf_bits_next = '0;
                                node_we    = 1'b1;
                                node_waddr = NODE_AW'(leaf_pos);
                                node_wdata = {1'b1, {(ENTRY_W-1-SYM_W){1'b0}}, new_shift};
                                if (leaf_pos == '0)
                                begin
                                    root_entry_next = node_wdata;
                                end
                                if (top_eff == '0)
                                begin
                                    if (byte_end)
                                    begin
                                        symbols_left_next = symbol_count_reg;
                                        cur_entry_next    = root_entry_next;
                                        phase_next = (symbol_count_reg == '0) ? PH_DONE
                                                                               : PH_DECODE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SKIP;
                                    end
                                end
                                else
                                begin
                                    // pop the parent waiting for its right link
                                    stack_top_next = top_eff - STACK_TW'(1);
                                    stk_re     = 1'b1;
                                    stk_raddr  = stack_top_next[STACK_AW-1:0];
                                    phase_next = PH_TREE;
                                    eng_next   = ENG_POP;
                                end
                            end
                        end
                        PH_SKIP:
                        begin
                            if (byte_end)
                            begin
                                symbols_left_next = symbol_count_reg;
                                cur_entry_next    = root_entry_reg;
                                phase_next = (symbol_count_reg == '0) ? PH_DONE : PH_DECODE;
                            end
                        end
                        PH_DECODE:
                        begin
                            if (root_entry_reg[LEAF_BIT])
                            begin
                                // single-leaf tree: every bit yields the root symbol
                                emit     = 1'b1;
                                emit_sym = root_entry_reg[SYM_W-1:0];
                            end
                            else
                            begin
                                node_re    = 1'b1;
                                node_raddr = walk_idx[NODE_AW-1:0];
                                eng_next   = ENG_WALK;
                            end
                        end
                        PH_DONE, PH_ERROR:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ENG_WALK:
            begin
                eng_next = ENG_IDLE;
                if (node_rdata[LEAF_BIT])
                begin
                    emit           = 1'b1;
                    emit_sym       = node_rdata[SYM_W-1:0];
                    cur_entry_next = root_entry_reg;
                end
                else
                begin
                    cur_entry_next = node_rdata;
                end
            end
            ENG_POP:
            begin
                // patch the right link; the left link is always parent + 1
                eng_next   = ENG_IDLE;
                node_we    = 1'b1;
                node_waddr = stk_rdata[NODE_AW-1:0];
                node_wdata = {1'b0, node_idx_t'(stk_rdata + node_idx_t'(1)),
                              NODE_IDX_W'(nodes_used_reg)};
                if (stk_rdata == '0)
                begin
                    root_entry_next = node_wdata;
                end
            end
            default:
            begin
                eng_next = ENG_IDLE;
            end
        endcase

        if (emit)
        begin
            symbols_left_next = symbols_left_reg - 32'd1;
            res.valid  = 1'b1;
            res.symbol = emit_sym;
            res.last   = (symbols_left_reg == 32'd1);
            if (symbols_left_reg == 32'd1)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TREE;
            eng_reg          <= ENG_IDLE;
            stack_top_reg    <= '0;
            nodes_used_reg   <= '0;
            leaf_shift_reg   <= '0;
            leaf_bits_reg    <= '0;
            symbols_left_reg <= '0;
            symbol_count_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            eng_reg          <= eng_next;
            stack_top_reg    <= stack_top_next;
            nodes_used_reg   <= nodes_used_next;
            leaf_shift_reg   <= leaf_shift_next;
            leaf_bits_reg    <= leaf_bits_next;
            symbols_left_reg <= symbols_left_next;
            if (cfg_we)
            begin
                symbol_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_entry_reg  <= cur_entry_next;
        root_entry_reg <= root_entry_next;
    end

    assign stat.walking = (eng_reg == ENG_WALK);
    assign stat.popping = (eng_reg == ENG_POP);

endmodule

[design/huffman_tree_load_and_decode.sv]
// Top level of the serialized-tree Huffman decoder: stream ports, RAMs, buffer.
// Depends on hufd_pkg, hufd_ram, hufd_ctrl and hufd_outq.
//
// One compressed bit enters per request on the slave stream; tlast marks the
// last bit of a byte and tuser marks the first tree bit of a new frame, which
// restarts tree loading from an empty stack and node count. Tree bits are
// taken one at a time; after the eighth symbol bit of a leaf whose parent
// still needs a right link, the pending-stack RAM is read and then the parent
// is patched in the node table before the next bit is taken. Each code bit
// waits for a read of the node table RAM on the walk from node to child before
// the next bit is taken; with a tree that is a single leaf no read is needed.
// Results leave through a two-entry buffer, so input keeps flowing while one
// result waits; a full buffer holds off new bits. The node table and stack
// start undefined and are never cleared: no clearing pass follows reset. Write
// symbol_count only while the block is idle; it is copied when decoding begins.
module huffman_tree_load_and_decode
    import hufd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] code_bit, [7:1] zero
    input  logic             s_tlast,   // byte_end
    input  logic             s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [SYM_W-1:0] m_tdata,   // [7:0] symbol
    output logic             m_tlast,   // last
    output logic             m_tuser    // [0] status
);

    result_t             res;
    ctrl_stat_t          stat;
    logic                q_full;

    logic                node_we;
    logic [NODE_AW-1:0]  node_waddr;
    entry_t              node_wdata;
    logic                node_re;
    logic [NODE_AW-1:0]  node_raddr;
    entry_t              node_rdata;

    logic                stk_we;
    logic [STACK_AW-1:0] stk_waddr;
    node_idx_t           stk_wdata;
    logic                stk_re;
    logic [STACK_AW-1:0] stk_raddr;
    node_idx_t           stk_rdata;

    // Node table: one entry per tree node, leaf flag plus links or symbol.
    hufd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_MAX)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Pending stack: internal nodes still missing a right child.
    hufd_ram #(
        .WIDTH (NODE_IDX_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    hufd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .code_bit    (s_tdata[0]),
        .byte_end    (s_tlast),
        .frame_start (s_tuser),
        .q_full      (q_full),
        .res         (res),
        .stat        (stat),
        .node_we     (node_we),
        .node_waddr  (node_waddr),
        .node_wdata  (node_wdata),
        .node_re     (node_re),
        .node_raddr  (node_raddr),
        .node_rdata  (node_rdata),
        .stk_we      (stk_we),
        .stk_waddr   (stk_waddr),
        .stk_wdata   (stk_wdata),
        .stk_re      (stk_re),
        .stk_raddr   (stk_raddr),
        .stk_rdata   (stk_rdata)
    );

    hufd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res),
        .full     (q_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // A result never lands in a full buffer unless the head drains that cycle.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && q_full) |-> m_tready)
        else $error("result pushed into full output buffer");

    // A node walk step only follows an accepted code bit.
    a_walk_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        stat.walking |-> $past(s_tvalid && s_tready))
        else $error("node walk without an accepted bit");

    // A right-link patch only follows a leaf bit that did not start a frame.
    a_pop_after_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        stat.popping |-> $past(s_tvalid && s_tready && !s_tuser))
        else $error("stack pop without a completing leaf bit");

endmodule
